// ----- rtl/mmts_pkg.sv -----
package mmts_pkg;

    localparam int ADDR_BITS = 16;
    localparam int IDX_W     = 17;
    localparam int AW        = 16;
    localparam int DW        = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [IDX_W-1:0] SIZE_CAP     = 17'h10000;
    localparam logic [IDX_W-1:0] SIZE_LIMIT   =
        (ADDR_BITS < 16) ? IDX_W'(64'd1 << ADDR_BITS) : SIZE_CAP;
    localparam logic [IDX_W-1:0] MEM_SIZE_RST = 17'h10000;

    localparam logic [0:0] REG_MEM_SIZE = 1'b0;

    localparam logic [2:0] FUNC_FILL    = 3'd0;
    localparam logic [2:0] FUNC_MARCH   = 3'd1;
    localparam logic [2:0] FUNC_CHECK   = 3'd2;
    localparam logic [2:0] FUNC_WR_DONE = 3'd3;
    localparam logic [2:0] FUNC_RD_DONE = 3'd4;

    localparam logic [DW-1:0] INIT_ZERO = 8'h00;
    localparam logic [DW-1:0] INIT_ONE  = 8'hFF;
    localparam logic [2:0]    LAST_BIT  = 3'd7;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_MARCH = 2'd2,
        MODE_CHECK = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ACC_READ    = 2'd0,
        ACC_WRITE   = 2'd1,
        ACC_DONE    = 2'd2,
        ACC_IGNORED = 2'd3
    } access_t;

    typedef struct packed {
        logic [2:0]    func;
        logic          direction;
        logic          action;
        logic [DW-1:0] read_data;
    } item_t;

    typedef struct packed {
        mode_t            mode;
        logic [IDX_W-1:0] byte_index;
        logic [2:0]       bit_step;
        logic [DW-1:0]    compare_value;
        logic             direction;
        logic             action;
        logic             mismatch_seen;
        logic [AW-1:0]    mismatch_address;
        logic             awaiting_read;
    } state_t;

    typedef struct packed {
        access_t       access;
        logic [AW-1:0] address;
        logic [DW-1:0] write_data;
        logic          failed;
        logic [AW-1:0] fail_address;
    } result_t;

    function automatic logic [AW-1:0] phys_addr(input logic [IDX_W-1:0] size,
                                                input logic [IDX_W-1:0] idx,
                                                input logic             dir);
        logic [IDX_W-1:0] rev;
        rev = size - IDX_W'(1) - idx;
        return dir ? rev[AW-1:0] : idx[AW-1:0];
    endfunction

    function automatic logic [DW-1:0] init_compare(input logic act);
        return act ? INIT_ONE : INIT_ZERO;
    endfunction

endpackage

// ----- rtl/mmts_cfg.sv -----
module mmts_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmts_pkg::PADDR_W-1:0]     paddr,
    input  logic [mmts_pkg::PDATA_W-1:0]     pwdata,
    output logic [mmts_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output logic [mmts_pkg::IDX_W-1:0]       mem_size
);

    logic [mmts_pkg::IDX_W-1:0] mem_size_reg;
    logic [mmts_pkg::IDX_W-1:0] mem_size_next;
    logic                       hit;

    // byte lane bits ignored, word index only
    assign hit = (paddr[2:2] == mmts_pkg::REG_MEM_SIZE);

    always_comb begin
        mem_size_next = mem_size_reg;
        if (psel && penable && pwrite && hit) begin
            mem_size_next = pwdata[mmts_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= mmts_pkg::MEM_SIZE_RST;
        end else begin
            mem_size_reg <= mem_size_next;
        end
    end

    assign prdata   = hit ? mmts_pkg::PDATA_W'(mem_size_reg) : '0;
    assign pready   = 1'b1;
    assign mem_size = mem_size_reg;

endmodule

// ----- rtl/mmts_step.sv -----
module mmts_step (
    input  mmts_pkg::item_t             item,
    input  mmts_pkg::state_t            st,
    input  logic [mmts_pkg::IDX_W-1:0]  mem_size,
    output mmts_pkg::state_t            st_next,
    output mmts_pkg::result_t           res
);

    logic [mmts_pkg::IDX_W-1:0] size_use;
    logic                       size_zero;
    logic                       is_start;
    logic                       wr_ok;
    logic                       rd_ok;
    logic [mmts_pkg::IDX_W-1:0] bi_inc;
    logic                       inc_end;
    logic [mmts_pkg::IDX_W-1:0] bi_march;
    logic [mmts_pkg::AW-1:0]    phys_cur;
    logic [mmts_pkg::AW-1:0]    phys_wr;
    logic [mmts_pkg::AW-1:0]    phys_start;
    logic [2:0]                 shift;
    logic [mmts_pkg::DW-1:0]    weight;
    logic [mmts_pkg::DW-1:0]    cmp_new;
    logic                       cmp_miss;

    assign size_use  = (mem_size > mmts_pkg::SIZE_LIMIT) ? mmts_pkg::SIZE_LIMIT : mem_size;
    assign size_zero = (size_use == '0);
    assign is_start  = (item.func == mmts_pkg::FUNC_FILL) || (item.func == mmts_pkg::FUNC_MARCH)
                    || (item.func == mmts_pkg::FUNC_CHECK);
    assign wr_ok     = (item.func == mmts_pkg::FUNC_WR_DONE) && (st.mode != mmts_pkg::MODE_IDLE)
                    && !st.awaiting_read;
    assign rd_ok     = (item.func == mmts_pkg::FUNC_RD_DONE) && (st.mode != mmts_pkg::MODE_IDLE)
                    && st.awaiting_read;

    assign bi_inc     = st.byte_index + mmts_pkg::IDX_W'(1);
    assign inc_end    = (bi_inc >= size_use);
    assign bi_march   = (st.bit_step == mmts_pkg::LAST_BIT) ? bi_inc : st.byte_index;
    assign phys_cur   = mmts_pkg::phys_addr(size_use, st.byte_index, st.direction);
    assign phys_wr    = mmts_pkg::phys_addr(size_use, bi_march, st.direction);
    assign phys_start = mmts_pkg::phys_addr(size_use, '0, item.direction);

    // lsb first ascending, msb first descending
    assign shift    = st.direction ? (mmts_pkg::LAST_BIT - st.bit_step) : st.bit_step;
    assign weight   = mmts_pkg::DW'(1) << shift;
    assign cmp_new  = st.action ? (st.compare_value - weight) : (st.compare_value + weight);
    assign cmp_miss = (item.read_data != st.compare_value);

    always_comb begin
        st_next = st;
        if (is_start) begin
            st_next.byte_index       = '0;
            st_next.bit_step         = '0;
            st_next.mismatch_seen    = 1'b0;
            st_next.mismatch_address = '0;
            st_next.compare_value    = mmts_pkg::INIT_ZERO;
            if (item.func == mmts_pkg::FUNC_MARCH) begin
                st_next.direction     = item.direction;
                st_next.action        = item.action;
                st_next.compare_value = mmts_pkg::init_compare(item.action);
            end
            if (size_zero) begin
                st_next.mode          = mmts_pkg::MODE_IDLE;
                st_next.awaiting_read = 1'b0;
            end else begin
                case (item.func)
                    mmts_pkg::FUNC_FILL: begin
                        st_next.mode          = mmts_pkg::MODE_FILL;
                        st_next.awaiting_read = 1'b0;
                    end
                    mmts_pkg::FUNC_MARCH: begin
                        st_next.mode          = mmts_pkg::MODE_MARCH;
                        st_next.awaiting_read = 1'b1;
                    end
                    default: begin
                        st_next.mode          = mmts_pkg::MODE_CHECK;
                        st_next.awaiting_read = 1'b1;
                    end
                endcase
            end
        end else if (wr_ok) begin
            if (st.mode == mmts_pkg::MODE_FILL) begin
                st_next.byte_index = bi_inc;
                if (inc_end) begin
                    st_next.mode          = mmts_pkg::MODE_IDLE;
                    st_next.awaiting_read = 1'b0;
                end
            end else if (st.mismatch_seen) begin
                st_next.mode          = mmts_pkg::MODE_IDLE;
                st_next.awaiting_read = 1'b0;
            end else if (st.bit_step == mmts_pkg::LAST_BIT) begin
                st_next.byte_index = bi_inc;
                if (inc_end) begin
                    st_next.mode          = mmts_pkg::MODE_IDLE;
                    st_next.awaiting_read = 1'b0;
                end else begin
                    st_next.bit_step      = '0;
                    st_next.compare_value = mmts_pkg::init_compare(st.action);
                    st_next.awaiting_read = 1'b1;
                end
            end else begin
                st_next.bit_step      = st.bit_step + 3'd1;
                st_next.awaiting_read = 1'b1;
            end
        end else if (rd_ok) begin
            if (st.mode == mmts_pkg::MODE_CHECK) begin
                if (item.read_data != '0) begin
                    st_next.mode          = mmts_pkg::MODE_IDLE;
                    st_next.awaiting_read = 1'b0;
                end else begin
                    st_next.byte_index = bi_inc;
                    if (inc_end) begin
                        st_next.mode          = mmts_pkg::MODE_IDLE;
                        st_next.awaiting_read = 1'b0;
                    end
                end
            end else begin
                if (cmp_miss && !st.mismatch_seen) begin
                    st_next.mismatch_seen    = 1'b1;
                    st_next.mismatch_address = phys_cur;
                end
                st_next.compare_value = cmp_new;
                st_next.awaiting_read = 1'b0;
            end
        end
    end

    always_comb begin
        res              = '0;
        res.access       = mmts_pkg::ACC_IGNORED;
        if (is_start) begin
            if (size_zero) begin
                res.access = mmts_pkg::ACC_DONE;
            end else if (item.func == mmts_pkg::FUNC_FILL) begin
                res.access = mmts_pkg::ACC_WRITE;
            end else begin
                res.access = mmts_pkg::ACC_READ;
                if (item.func == mmts_pkg::FUNC_MARCH) begin
                    res.address = phys_start;
                end
            end
        end else if (wr_ok) begin
            if (st.mode == mmts_pkg::MODE_FILL) begin
                if (inc_end) begin
                    res.access = mmts_pkg::ACC_DONE;
                end else begin
                    res.access  = mmts_pkg::ACC_WRITE;
                    res.address = bi_inc[mmts_pkg::AW-1:0];
                end
            end else if (st.mismatch_seen) begin
                res.access       = mmts_pkg::ACC_DONE;
                res.failed       = 1'b1;
                res.fail_address = st.mismatch_address;
            end else if ((st.bit_step == mmts_pkg::LAST_BIT) && inc_end) begin
                res.access = mmts_pkg::ACC_DONE;
            end else begin
                res.access  = mmts_pkg::ACC_READ;
                res.address = phys_wr;
            end
        end else if (rd_ok) begin
            if (st.mode == mmts_pkg::MODE_CHECK) begin
                if (item.read_data != '0) begin
                    res.access       = mmts_pkg::ACC_DONE;
                    res.failed       = 1'b1;
                    res.fail_address = st.byte_index[mmts_pkg::AW-1:0];
                end else if (inc_end) begin
                    res.access = mmts_pkg::ACC_DONE;
                end else begin
                    res.access  = mmts_pkg::ACC_READ;
                    res.address = bi_inc[mmts_pkg::AW-1:0];
                end
            end else begin
                res.access     = mmts_pkg::ACC_WRITE;
                res.address    = phys_cur;
                res.write_data = cmp_new;
            end
        end
    end

endmodule

// ----- rtl/march_memory_test_sequencer_core.sv -----
// march memory self-test sequencer
// input channel (s_*): start commands (fill zero, march, check zero) and
// memory completions (write done, read done with the byte read)
// result channel (m_*): one word per input word - the next read or write to
// issue, element finished with pass/fail and first failing address, or
// ignored for a completion that does not fit the running element
// apb port: mem_size at address 0, to be written by the user only while no
// word is in flight (not enforced by the block); a new size takes effect at
// once, also in a running element
// path: input register, then next-access logic into the result register
// throughput: one word per cycle while m_ready is high; the input register
// and the result register are separate stages, so a new word is taken while
// a result waits; receiver stall: the result register holds, the input
// register holds one more word, then s_ready drops until m_ready returns
// reset: both stages empty, element idle, mem_size set to 65536
module march_memory_test_sequencer_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_func,
    input  logic                         s_direction,
    input  logic                         s_action,
    input  logic [7:0]                   s_read_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_access,
    output logic [15:0]                  m_address,
    output logic [7:0]                   m_write_data,
    output logic                         m_failed,
    output logic [15:0]                  m_fail_address,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mmts_pkg::PADDR_W-1:0] paddr,
    input  logic [mmts_pkg::PDATA_W-1:0] pwdata,
    output logic [mmts_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    logic                       in_valid_reg;
    logic                       in_valid_next;
    mmts_pkg::item_t            item_reg;
    mmts_pkg::item_t            item_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    mmts_pkg::result_t          res_reg;
    mmts_pkg::result_t          res_next;
    mmts_pkg::state_t           state_reg;
    mmts_pkg::state_t           state_next;
    mmts_pkg::state_t           step_state;
    mmts_pkg::result_t          step_res;
    logic [mmts_pkg::IDX_W-1:0] mem_size;
    logic                       fire;
    logic                       s_fire;

    mmts_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .mem_size (mem_size)
    );

    mmts_step u_step (
        .item     (item_reg),
        .st       (state_reg),
        .mem_size (mem_size),
        .st_next  (step_state),
        .res      (step_res)
    );

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        state_next     = state_reg;
        if (fire) begin
            in_valid_next = 1'b0;
            state_next    = step_state;
            res_next      = step_res;
        end
        if (s_fire) begin
            in_valid_next       = 1'b1;
            item_next.func      = s_func;
            item_next.direction = s_direction;
            item_next.action    = s_action;
            item_next.read_data = s_read_data;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_access       = res_reg.access;
    assign m_address      = res_reg.address;
    assign m_write_data   = res_reg.write_data;
    assign m_failed       = res_reg.failed;
    assign m_fail_address = res_reg.fail_address;

`ifndef SYNTHESIS
    a_fail_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_failed) |-> (m_access == mmts_pkg::ACC_DONE))
        else $error("fail flag on a word that is not finished");

    a_ignored_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_access == mmts_pkg::ACC_IGNORED)) |->
        ((m_address == '0) && (m_write_data == '0) && !m_failed && (m_fail_address == '0)))
        else $error("ignored word carries payload");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (step_res.access == mmts_pkg::ACC_DONE)) |=>
        (state_reg.mode == mmts_pkg::MODE_IDLE))
        else $error("element still running after finished word");

    a_held_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(item_reg)))
        else $error("waiting input word lost");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

class sequencer_model;
    logic [mmts_pkg::IDX_W-1:0] mem_size;
    mmts_pkg::mode_t            mode;
    int                         byte_idx;
    logic [2:0]                 step;
    logic [mmts_pkg::DW-1:0]    cmp;
    logic                       dir;
    logic                       act;
    logic                       miss;
    logic [mmts_pkg::AW-1:0]    miss_addr;
    logic                       awaiting_rd;
    mmts_pkg::result_t          pending_access[$];
    int                         errors;

    function new();
        mem_size    = mmts_pkg::MEM_SIZE_RST;
        mode        = mmts_pkg::MODE_IDLE;
        byte_idx    = 0;
        step        = '0;
        cmp         = '0;
        dir         = 1'b0;
        act         = 1'b0;
        miss        = 1'b0;
        miss_addr   = '0;
        awaiting_rd = 1'b0;
        errors      = 0;
    endfunction

    function void set_size(logic [mmts_pkg::IDX_W-1:0] value);
        mem_size = value;
    endfunction

    function int active_size();
        longint s;
        s = mem_size;
        if (s > 65536) s = 65536;
        if (s > (longint'(1) << mmts_pkg::ADDR_BITS)) s = longint'(1) << mmts_pkg::ADDR_BITS;
        return int'(s);
    endfunction

    function logic [mmts_pkg::AW-1:0] target_addr(int sz);
        return dir ? mmts_pkg::AW'(sz - 1 - byte_idx) : mmts_pkg::AW'(byte_idx);
    endfunction

    function logic [mmts_pkg::DW-1:0] start_value();
        return act ? mmts_pkg::INIT_ONE : mmts_pkg::INIT_ZERO;
    endfunction

    function mmts_pkg::result_t finished(logic fl, logic [mmts_pkg::AW-1:0] fa);
        mmts_pkg::result_t r;
        r = '0;
        mode = mmts_pkg::MODE_IDLE;
        awaiting_rd = 1'b0;
        r.access = mmts_pkg::ACC_DONE;
        r.failed = fl;
        r.fail_address = fl ? fa : '0;
        return r;
    endfunction

    // works out the next access for one accepted word and queues it
    function mmts_pkg::result_t note_command(mmts_pkg::item_t it);
        mmts_pkg::result_t       r;
        int                      sz;
        logic [mmts_pkg::AW-1:0] a;
        logic [2:0]              sh;
        logic [mmts_pkg::DW-1:0] w;
        logic                    ended;
        r = '0;
        r.access = mmts_pkg::ACC_IGNORED;
        sz = active_size();
        ended = 1'b0;
        if (it.func <= mmts_pkg::FUNC_CHECK) begin
            byte_idx = 0;
            step = '0;
            miss = 1'b0;
            miss_addr = '0;
            if (it.func == mmts_pkg::FUNC_MARCH) begin
                dir = it.direction;
                act = it.action;
            end
            cmp = (it.func == mmts_pkg::FUNC_MARCH) ? start_value() : mmts_pkg::INIT_ZERO;
            if (sz == 0) begin
                r = finished(1'b0, '0);
            end else if (it.func == mmts_pkg::FUNC_FILL) begin
                mode = mmts_pkg::MODE_FILL;
                awaiting_rd = 1'b0;
                r.access = mmts_pkg::ACC_WRITE;
            end else begin
                mode = (it.func == mmts_pkg::FUNC_MARCH) ? mmts_pkg::MODE_MARCH
                                                         : mmts_pkg::MODE_CHECK;
                awaiting_rd = 1'b1;
                r.access = mmts_pkg::ACC_READ;
                r.address = (it.func == mmts_pkg::FUNC_MARCH) ? target_addr(sz) : '0;
            end
        end else if (it.func == mmts_pkg::FUNC_WR_DONE && mode != mmts_pkg::MODE_IDLE
                     && !awaiting_rd) begin
            if (mode == mmts_pkg::MODE_FILL) begin
                byte_idx++;
                if (byte_idx >= sz) begin
                    r = finished(1'b0, '0);
                end else begin
                    r.access = mmts_pkg::ACC_WRITE;
                    r.address = mmts_pkg::AW'(byte_idx);
                end
            end else if (miss) begin
                r = finished(1'b1, miss_addr);
            end else begin
                if (step == mmts_pkg::LAST_BIT) begin
                    byte_idx++;
                    if (byte_idx >= sz) begin
                        r = finished(1'b0, '0);
                        ended = 1'b1;
                    end else begin
                        step = '0;
                        cmp = start_value();
                    end
                end else begin
                    step++;
                end
                if (!ended) begin
                    awaiting_rd = 1'b1;
                    r.access = mmts_pkg::ACC_READ;
                    r.address = target_addr(sz);
                end
            end
        end else if (it.func == mmts_pkg::FUNC_RD_DONE && mode != mmts_pkg::MODE_IDLE
                     && awaiting_rd) begin
            if (mode == mmts_pkg::MODE_CHECK) begin
                if (it.read_data != '0) begin
                    r = finished(1'b1, mmts_pkg::AW'(byte_idx));
                end else begin
                    byte_idx++;
                    if (byte_idx >= sz) begin
                        r = finished(1'b0, '0);
                    end else begin
                        r.access = mmts_pkg::ACC_READ;
                        r.address = mmts_pkg::AW'(byte_idx);
                    end
                end
            end else begin
                a = target_addr(sz);
                sh = dir ? (mmts_pkg::LAST_BIT - step) : step;
                w = mmts_pkg::DW'(1) << sh;
                if (it.read_data != cmp && !miss) begin
                    miss = 1'b1;
                    miss_addr = a;
                end
                cmp = act ? cmp - w : cmp + w;
                awaiting_rd = 1'b0;
                r.access = mmts_pkg::ACC_WRITE;
                r.address = a;
                r.write_data = cmp;
            end
        end
        pending_access.push_back(r);
        return r;
    endfunction

    function void compare_field(string field, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endfunction

    function void check_access(mmts_pkg::result_t got);
        mmts_pkg::result_t want;
        if (pending_access.size() == 0) begin
            errors++;
            $display("%0t: access expected none got %0h", $time, got.access);
            return;
        end
        want = pending_access.pop_front();
        compare_field("access", want.access, got.access);
        compare_field("address", want.address, got.address);
        compare_field("write_data", want.write_data, got.write_data);
        compare_field("failed", want.failed, got.failed);
        compare_field("fail_address", want.fail_address, got.fail_address);
    endfunction
endclass

module testbench;

    localparam int RANDOM_WORDS = 1950;
    localparam int QUIET_WORDS  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [2:0]                   s_func = mmts_pkg::FUNC_WR_DONE;
    logic                         s_direction = 1'b0;
    logic                         s_action = 1'b0;
    logic [mmts_pkg::DW-1:0]      s_read_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b1;
    logic [1:0]                   m_access;
    logic [mmts_pkg::AW-1:0]      m_address;
    logic [mmts_pkg::DW-1:0]      m_write_data;
    logic                         m_failed;
    logic [mmts_pkg::AW-1:0]      m_fail_address;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [mmts_pkg::PADDR_W-1:0] paddr = '0;
    logic [mmts_pkg::PDATA_W-1:0] pwdata = '0;
    logic [mmts_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    sequencer_model          sb;
    mmts_pkg::result_t       last_op;
    logic [mmts_pkg::DW-1:0] mem [0:65535];
    int                      done_words = 0;
    int                      prog_step = 0;
    logic                    quiet = 1'b0;
    logic                    gaps_on = 1'b1;
    logic                    stalls_on = 1'b1;

    march_memory_test_sequencer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_direction    (s_direction),
        .s_action       (s_action),
        .s_read_data    (s_read_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_access       (m_access),
        .m_address      (m_address),
        .m_write_data   (m_write_data),
        .m_failed       (m_failed),
        .m_fail_address (m_fail_address),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("testbench: FAIL");
        $finish;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && stalls_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        mmts_pkg::result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.access       = mmts_pkg::access_t'(m_access);
            got.address      = m_address;
            got.write_data   = m_write_data;
            got.failed       = m_failed;
            got.fail_address = m_fail_address;
            sb.check_access(got);
        end
    end

    function automatic mmts_pkg::item_t mk(logic [2:0] f, logic d, logic a,
                                           logic [mmts_pkg::DW-1:0] rd);
        mmts_pkg::item_t it;
        it.func      = f;
        it.direction = d;
        it.action    = a;
        it.read_data = rd;
        return it;
    endfunction

    task automatic issue(mmts_pkg::item_t it);
        mmts_pkg::result_t r;
        if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= it.func;
        s_direction <= it.direction;
        s_action    <= it.action;
        s_read_data <= it.read_data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = sb.note_command(it);
        if (r.access != mmts_pkg::ACC_IGNORED) begin
            last_op = r;
            done_words++;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_access.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic set_mem_size(logic [mmts_pkg::IDX_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mmts_pkg::PADDR_W'(4 * mmts_pkg::REG_MEM_SIZE);
        pwdata  <= {(mmts_pkg::PDATA_W - mmts_pkg::IDX_W)'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_size(value);
    endtask

    // fill, check, the four march elements, check again, with a random start at times
    function automatic mmts_pkg::item_t next_start(mmts_pkg::item_t it);
        if ($urandom_range(0, 9) == 0) begin
            it.func = 3'($urandom_range(mmts_pkg::FUNC_FILL, mmts_pkg::FUNC_CHECK));
            return it;
        end
        case (prog_step)
            0: it.func = mmts_pkg::FUNC_FILL;
            1, 6: it.func = mmts_pkg::FUNC_CHECK;
            default: begin
                it.func = mmts_pkg::FUNC_MARCH;
                it.direction = (prog_step >= 4);
                it.action = (prog_step == 3 || prog_step == 5);
            end
        endcase
        prog_step = (prog_step + 1) % 7;
        return it;
    endfunction

    // plays the memory under test, with the odd fault, stray word or restart
    function automatic mmts_pkg::item_t next_word();
        mmts_pkg::item_t it;
        int              roll;
        it = mk(mmts_pkg::FUNC_WR_DONE, 1'($urandom), 1'($urandom),
                mmts_pkg::DW'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            it.func = 3'($urandom_range(0, 7));
        end else if (roll < 7
                     && last_op.access inside {mmts_pkg::ACC_READ, mmts_pkg::ACC_WRITE}) begin
            it.func = (last_op.access == mmts_pkg::ACC_READ) ? mmts_pkg::FUNC_WR_DONE
                                                             : mmts_pkg::FUNC_RD_DONE;
        end else begin
            case (last_op.access)
                mmts_pkg::ACC_READ: begin
                    it.func = mmts_pkg::FUNC_RD_DONE;
                    it.read_data = mem[last_op.address];
                    if ($urandom_range(0, 79) == 0)
                        it.read_data ^= mmts_pkg::DW'(1) << $urandom_range(0, 7);
                end
                mmts_pkg::ACC_WRITE: begin
                    mem[last_op.address] = last_op.write_data;
                    it.func = mmts_pkg::FUNC_WR_DONE;
                end
                default: it = next_start(it);
            endcase
        end
        return it;
    endfunction

    initial begin
        int                         roll;
        int                         phase_len;
        logic [mmts_pkg::IDX_W-1:0] next_size;
        sb = new();
        last_op = '0;
        last_op.access = mmts_pkg::ACC_DONE;
        for (int i = 0; i < 65536; i++) mem[i] = mmts_pkg::DW'($urandom);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // top address at reset size, then resize under a running march
        issue(mk(mmts_pkg::FUNC_MARCH, 1'b1, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b0, 8'h00));
        set_mem_size(17'd1);
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b0, 1'b1, 8'hFF));
        issue(mk(mmts_pkg::FUNC_FILL, 1'b1, 1'b1, 8'hFF));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b1, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b1, 8'hFF));
        issue(mk(3'd5, 1'b1, 1'b1, 8'hFF));
        issue(mk(3'd6, 1'b0, 1'b1, 8'h0F));
        issue(mk(3'd7, 1'b1, 1'b0, 8'hF0));
        issue(mk(mmts_pkg::FUNC_CHECK, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b1, 1'b1, 8'h00));
        issue(mk(mmts_pkg::FUNC_CHECK, 1'b1, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b0, 8'h80));
        issue(mk(mmts_pkg::FUNC_MARCH, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b0, 8'h55));
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_MARCH, 1'b1, 1'b1, 8'h00));
        issue(mk(mmts_pkg::FUNC_RD_DONE, 1'b0, 1'b0, 8'hFF));
        set_mem_size(17'd0);
        issue(mk(mmts_pkg::FUNC_WR_DONE, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_FILL, 1'b0, 1'b0, 8'h00));
        issue(mk(mmts_pkg::FUNC_MARCH, 1'b1, 1'b0, 8'h00));

        done_words = 0;
        while (done_words < RANDOM_WORDS) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                next_size = mmts_pkg::IDX_W'($urandom_range(1, 6));
            else if (roll < 70)
                next_size = mmts_pkg::IDX_W'($urandom_range(7, 40));
            else if (roll < 76)
                next_size = '0;
            else if (roll < 82)
                next_size = 17'h10000;
            else if (roll < 87)
                next_size = 17'h1FFFF;
            else if (roll < 92)
                next_size = 17'h0FFFF;
            else
                next_size = mmts_pkg::IDX_W'($urandom_range(0, 131071));
            set_mem_size(next_size);
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            phase_len = (next_size > 64) ? $urandom_range(20, 60) : $urandom_range(60, 220);
            for (int k = 0; k < phase_len && done_words < RANDOM_WORDS; k++) begin
                quiet = (done_words >= RANDOM_WORDS - QUIET_WORDS);
                issue(next_word());
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_access.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mmts_pkg.sv
rtl/mmts_cfg.sv
rtl/mmts_step.sv
rtl/march_memory_test_sequencer_core.sv
tb/testbench.sv
